// File: rtl/imfe_pkg.sv
// ----------------------------------------------------------------------------
// imfe_pkg
// shared widths, register codes, reset values and pipeline types for the
// imu motion feature extract unit
// ----------------------------------------------------------------------------
`default_nettype none

package imfe_pkg;

   // sample and result field width
   localparam int FIELD_W = 16;

   // configuration register widths
   localparam int GRAVITY_W = 16;
   localparam int GAIN_W    = 18;
   localparam int CSR_DATA_W  = 18;
   localparam int CSR_INDEX_W = 2;

   // configuration reset values
   localparam logic [GRAVITY_W-1:0] GRAVITY_RESET       = 16'd16384;
   localparam logic [GAIN_W-1:0]    MOTION_GAIN_RESET   = 18'd104858;
   localparam logic [GAIN_W-1:0]    ROTATION_GAIN_RESET = 18'd91072;

   // register index codes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_GRAVITY_LEVEL = 2'd0,
      CSR_MOTION_GAIN   = 2'd1,
      CSR_ROTATION_GAIN = 2'd2
   } csr_index_type;

   // arithmetic widths
   localparam int SQ_W    = 2 * FIELD_W;        // square and sum of squares
   localparam int ROOT_W  = FIELD_W;            // floor sqrt of a 32-bit sum
   localparam int REM_W   = ROOT_W + 2;         // sqrt partial remainder
   localparam int PROD_W  = FIELD_W + GAIN_W;   // gain product
   localparam int SCALE_SHIFT = 16;

   // pipeline depth
   localparam int SQRT_STEPS   = SQ_W / 2;
   localparam int LANE_STAGES  = 2 + SQRT_STEPS;  // squares, sum, root bits
   localparam int MERGE_STAGES = 2;               // product, saturate
   localparam int PIPE_STAGES  = LANE_STAGES + MERGE_STAGES;

   // configuration as seen by the merge stage
   typedef struct packed {
      logic [GRAVITY_W-1:0] gravity_level;
      logic [GAIN_W-1:0]    motion_gain;
      logic [GAIN_W-1:0]    rotation_gain;
   } cfg_type;

   // one step of the digit-by-digit square root
   typedef struct packed {
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
      logic [SQ_W-1:0]   bits;
   } sqrt_stage_type;

endpackage

`default_nettype wire

// File: rtl/imfe_mag_lane.sv
// ----------------------------------------------------------------------------
// imfe_mag_lane
// one vector lane: squares the three axes, sums them and takes the floor
// square root one result bit per stage
// ----------------------------------------------------------------------------
`default_nettype none

module imfe_mag_lane (
   input  wire logic                                    clock,
   input  wire logic [imfe_pkg::LANE_STAGES-1:0]        stage_en,
   input  wire logic signed [imfe_pkg::FIELD_W-1:0]     axis_x,
   input  wire logic signed [imfe_pkg::FIELD_W-1:0]     axis_y,
   input  wire logic signed [imfe_pkg::FIELD_W-1:0]     axis_z,
   output logic [imfe_pkg::ROOT_W-1:0]                  magnitude
);
   import imfe_pkg::*;

   // one root bit: bring down two bits, try (root << 2) | 1
   function automatic sqrt_stage_type sqrt_step(input sqrt_stage_type s);
      logic [REM_W-1:0] shifted;
      logic [REM_W-1:0] trial;
      sqrt_stage_type   r;
      shifted = {s.rem[REM_W-3:0], s.bits[SQ_W-1 -: 2]};
      trial   = {s.root, 2'b01};
      if (shifted >= trial) begin
         r.rem  = shifted - trial;
         r.root = {s.root[ROOT_W-2:0], 1'b1};
      end else begin
         r.rem  = shifted;
         r.root = {s.root[ROOT_W-2:0], 1'b0};
      end
      r.bits = {s.bits[SQ_W-3:0], 2'b00};
      return r;
   endfunction

   logic [SQ_W-1:0] sq_x_ff, sq_y_ff, sq_z_ff;
   logic [SQ_W-1:0] sum_ff;
   sqrt_stage_type  st_ff [SQRT_STEPS];
   sqrt_stage_type  st_in [SQRT_STEPS];
   sqrt_stage_type  seed;

   // stage 0: axis squares, sign extended to full width first
   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         sq_x_ff <= $unsigned(SQ_W'(axis_x) * SQ_W'(axis_x));
         sq_y_ff <= $unsigned(SQ_W'(axis_y) * SQ_W'(axis_y));
         sq_z_ff <= $unsigned(SQ_W'(axis_z) * SQ_W'(axis_z));
      end
   end

   // stage 1: sum of squares, at most 3 * 2^30 so it fits 32 bits
   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         sum_ff <= sq_x_ff + sq_y_ff + sq_z_ff;
      end
   end

   // root stages, msb first
   always_comb begin
      seed.rem  = '0;
      seed.root = '0;
      seed.bits = sum_ff;
      st_in[0]  = sqrt_step(seed);
      for (int j = 1; j < SQRT_STEPS; j++) begin
         st_in[j] = sqrt_step(st_ff[j-1]);
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < SQRT_STEPS; j++) begin
         if (stage_en[2+j]) begin
            st_ff[j] <= st_in[j];
         end
      end
   end

   assign magnitude = st_ff[SQRT_STEPS-1].root;

endmodule

`default_nettype wire

// File: rtl/imfe_scale_merge.sv
// ----------------------------------------------------------------------------
// imfe_scale_merge
// merges the two lane magnitudes: gravity deviation, gain products, shift
// by 16 and saturation into the result register
// ----------------------------------------------------------------------------
`default_nettype none

module imfe_scale_merge (
   input  wire logic                                 clock,
   input  wire logic [imfe_pkg::MERGE_STAGES-1:0]    stage_en,
   input  wire imfe_pkg::cfg_type                    cfg,
   input  wire logic [imfe_pkg::ROOT_W-1:0]          accel_mag,
   input  wire logic [imfe_pkg::ROOT_W-1:0]          gyro_mag,
   output logic [imfe_pkg::FIELD_W-1:0]              motion_level,
   output logic [imfe_pkg::FIELD_W-1:0]              rotation_level
);
   import imfe_pkg::*;

   logic [ROOT_W-1:0]  dev;
   logic [PROD_W-1:0]  motion_prod_ff, rotation_prod_ff;
   logic [FIELD_W-1:0] motion_ff, rotation_ff;

   // absolute deviation from one g
   always_comb begin
      if (accel_mag >= cfg.gravity_level) begin
         dev = accel_mag - cfg.gravity_level;
      end else begin
         dev = cfg.gravity_level - accel_mag;
      end
   end

   // gain products
   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         motion_prod_ff   <= PROD_W'(dev) * PROD_W'(cfg.motion_gain);
         rotation_prod_ff <= PROD_W'(gyro_mag) * PROD_W'(cfg.rotation_gain);
      end
   end

   // shift by 16 and clamp to full scale
   function automatic logic [FIELD_W-1:0] shift_sat(input logic [PROD_W-1:0] p);
      if (|p[PROD_W-1:SCALE_SHIFT+FIELD_W]) begin
         return '1;
      end
      return p[SCALE_SHIFT +: FIELD_W];
   endfunction

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         motion_ff   <= shift_sat(motion_prod_ff);
         rotation_ff <= shift_sat(rotation_prod_ff);
      end
   end

   assign motion_level   = motion_ff;
   assign rotation_level = rotation_ff;

endmodule

`default_nettype wire

// File: rtl/imu_motion_feature_extract_unit.sv
// pipeline: 20 register stages; an accepted item reaches rsp_tvalid after
// passing through all of them; throughput: one item per cycle while
// rsp_tready is high, set by the fully pipelined root stages
// stalls: a held result only fills the pipeline bubbles in front of it
// reset: synchronous, clears all stage valids and loads the register defaults
// ----------------------------------------------------------------------------
// imu_motion_feature_extract_unit
// six-axis sample to motion and rotation levels: two magnitude lanes
// (accel, gyro) feed a merge stage that scales and saturates
// ----------------------------------------------------------------------------
`default_nettype none

module imu_motion_feature_extract_unit (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // input items
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z (16 bits each)
   input  wire logic [6*imfe_pkg::FIELD_W-1:0]       req_tdata,
   // result items
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // motion_level, rotation_level (16 bits each)
   output logic [2*imfe_pkg::FIELD_W-1:0]            rsp_tdata,
   // register writes
   input  wire logic                                 csr_wen,
   input  wire logic [imfe_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [imfe_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import imfe_pkg::*;

   cfg_type                  cfg_ff;
   logic [PIPE_STAGES-1:0]   valid_ff;
   logic [PIPE_STAGES-1:0]   valid_in;
   logic [PIPE_STAGES-1:0]   en;
   logic [ROOT_W-1:0]        accel_mag, gyro_mag;
   logic [FIELD_W-1:0]       motion_level, rotation_level;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gravity_level <= GRAVITY_RESET;
         cfg_ff.motion_gain   <= MOTION_GAIN_RESET;
         cfg_ff.rotation_gain <= ROTATION_GAIN_RESET;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_GRAVITY_LEVEL: cfg_ff.gravity_level <= csr_wdata[GRAVITY_W-1:0];
            CSR_MOTION_GAIN:   cfg_ff.motion_gain   <= csr_wdata[GAIN_W-1:0];
            CSR_ROTATION_GAIN: cfg_ff.rotation_gain <= csr_wdata[GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   // stage advance: a stage moves when empty or when the next one moves
   always_comb begin
      en[PIPE_STAGES-1] = !valid_ff[PIPE_STAGES-1] || rsp_tready;
      for (int i = PIPE_STAGES-2; i >= 0; i--) begin
         en[i] = !valid_ff[i] || en[i+1];
      end
   end

   // valid pipeline
   always_comb begin
      valid_in = valid_ff;
      if (en[0]) begin
         valid_in[0] = req_tvalid;
      end
      for (int i = 1; i < PIPE_STAGES; i++) begin
         if (en[i]) begin
            valid_in[i] = valid_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_tready = en[0];
   assign rsp_tvalid = valid_ff[PIPE_STAGES-1];

   // accel lane
   imfe_mag_lane u_accel_lane (
      .clock     (clock),
      .stage_en  (en[LANE_STAGES-1:0]),
      .axis_x    (req_tdata[0*FIELD_W +: FIELD_W]),
      .axis_y    (req_tdata[1*FIELD_W +: FIELD_W]),
      .axis_z    (req_tdata[2*FIELD_W +: FIELD_W]),
      .magnitude (accel_mag)
   );

   // gyro lane
   imfe_mag_lane u_gyro_lane (
      .clock     (clock),
      .stage_en  (en[LANE_STAGES-1:0]),
      .axis_x    (req_tdata[3*FIELD_W +: FIELD_W]),
      .axis_y    (req_tdata[4*FIELD_W +: FIELD_W]),
      .axis_z    (req_tdata[5*FIELD_W +: FIELD_W]),
      .magnitude (gyro_mag)
   );

   // merge, scale and saturate
   imfe_scale_merge u_merge (
      .clock          (clock),
      .stage_en       (en[PIPE_STAGES-1:LANE_STAGES]),
      .cfg            (cfg_ff),
      .accel_mag      (accel_mag),
      .gyro_mag       (gyro_mag),
      .motion_level   (motion_level),
      .rotation_level (rotation_level)
   );

   assign rsp_tdata = {rotation_level, motion_level};

   // pipeline empty right after a reset edge
   a_reset_empty: assert property (@(posedge clock)
      reset |=> valid_ff == '0)
      else $error("pipeline not empty after reset");

   // input is held off only when every stage holds an item
   a_full_when_blocked: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> &valid_ff)
      else $error("input blocked while a pipeline bubble exists");

   // an accepted item lands in the first stage
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> valid_ff[0])
      else $error("accepted item lost at pipeline entry");

   // a stalled result stage keeps its item
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      valid_ff[PIPE_STAGES-1] && !en[PIPE_STAGES-1] |=> valid_ff[PIPE_STAGES-1])
      else $error("result dropped while stalled");

endmodule

`default_nettype wire

// File: verif/imu_motion_feature_extract_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// imu_motion_feature_extract_unit_tb
// streams six-axis samples through the unit under random sender gaps and
// receiver stalls, predicts motion and rotation levels for every accepted
// item and compares them in order, over several register settings
// ----------------------------------------------------------------------------

module imu_motion_feature_extract_unit_tb;

   import imfe_pkg::*;

   localparam int CLOCK_HALF      = 2;
   localparam int RESET_CYCLES    = 9;
   localparam int SETTLE_CYCLES   = 30;      // a little over the pipeline latency
   localparam int CYCLE_LIMIT     = 400000;
   localparam int SETTING_PHASES  = 8;
   localparam int PHASE_ITEMS     = 235;
   localparam int MAX_WAIT        = 6;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_INDEX = 2'd3;
   localparam logic [GAIN_W-1:0]      GAIN_MAX         = 18'h3FFFF;
   localparam int unsigned            LEVEL_MAX        = 65535;

   // sample fields, accel_x in the lowest bits
   typedef struct packed {
      logic signed [FIELD_W-1:0] gyro_z;
      logic signed [FIELD_W-1:0] gyro_y;
      logic signed [FIELD_W-1:0] gyro_x;
      logic signed [FIELD_W-1:0] accel_z;
      logic signed [FIELD_W-1:0] accel_y;
      logic signed [FIELD_W-1:0] accel_x;
   } imu_sample_type;

   // result fields, motion_level in the lowest bits
   typedef struct packed {
      logic [FIELD_W-1:0] rotation_level;
      logic [FIELD_W-1:0] motion_level;
   } motion_levels_type;

   // predicted levels and in-order comparison
   class feature_scoreboard_type;
      logic [GRAVITY_W-1:0] gravity_level;
      logic [GAIN_W-1:0]    motion_gain;
      logic [GAIN_W-1:0]    rotation_gain;
      motion_levels_type    expected_levels[$];
      int                   errors;

      function new();
         gravity_level = GRAVITY_RESET;
         motion_gain   = MOTION_GAIN_RESET;
         rotation_gain = ROTATION_GAIN_RESET;
         errors        = 0;
      endfunction

      // registers keep their low bits, unknown indexes are dropped
      function void write_register(logic [CSR_INDEX_W-1:0] index,
                                   logic [CSR_DATA_W-1:0] value);
         case (csr_index_type'(index))
            CSR_GRAVITY_LEVEL: gravity_level = value[GRAVITY_W-1:0];
            CSR_MOTION_GAIN:   motion_gain   = value[GAIN_W-1:0];
            CSR_ROTATION_GAIN: rotation_gain = value[GAIN_W-1:0];
            default: ;
         endcase
      endfunction

      // floor square root, one result bit at a time from the top
      function logic [FIELD_W-1:0] floor_root(longint unsigned n);
         longint unsigned root;
         longint unsigned trial;
         root = 0;
         for (int b = FIELD_W - 1; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= n)
               root = trial;
         end
         return root[FIELD_W-1:0];
      endfunction

      function logic [FIELD_W-1:0] vector_length(logic signed [FIELD_W-1:0] a,
                                                 logic signed [FIELD_W-1:0] b,
                                                 logic signed [FIELD_W-1:0] c);
         longint sa;
         longint sb;
         longint sc;
         sa = a;
         sb = b;
         sc = c;
         return floor_root(longint'(sa * sa + sb * sb + sc * sc));
      endfunction

      // q16 gain, truncating shift, saturate at full scale
      function logic [FIELD_W-1:0] scale_level(logic [FIELD_W-1:0] x,
                                               logic [GAIN_W-1:0] gain);
         longint unsigned scaled;
         scaled = (longint'(x) * longint'(gain)) >> SCALE_SHIFT;
         return (scaled > LEVEL_MAX) ? LEVEL_MAX[FIELD_W-1:0] : scaled[FIELD_W-1:0];
      endfunction

      function void note_sample(imu_sample_type s);
         logic [FIELD_W-1:0] accel_len;
         logic [FIELD_W-1:0] gyro_len;
         logic [FIELD_W-1:0] deviation;
         motion_levels_type  levels;
         accel_len = vector_length(s.accel_x, s.accel_y, s.accel_z);
         gyro_len  = vector_length(s.gyro_x, s.gyro_y, s.gyro_z);
         deviation = (accel_len >= gravity_level) ? accel_len - gravity_level
                                                  : gravity_level - accel_len;
         levels.motion_level   = scale_level(deviation, motion_gain);
         levels.rotation_level = scale_level(gyro_len, rotation_gain);
         expected_levels.push_back(levels);
      endfunction

      function void check_result(motion_levels_type got);
         motion_levels_type want;
         if (expected_levels.size() == 0) begin
            $error("result item with none expected: %h", got);
            errors++;
            return;
         end
         want = expected_levels.pop_front();
         if (got.motion_level !== want.motion_level) begin
            $error("motion_level expected %0d got %0d", want.motion_level, got.motion_level);
            errors++;
         end
         if (got.rotation_level !== want.rotation_level) begin
            $error("rotation_level expected %0d got %0d",
                   want.rotation_level, got.rotation_level);
            errors++;
         end
      endfunction

      function int pending();
         return expected_levels.size();
      endfunction
   endclass

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   req_tvalid  = 1'b0;
   logic                   req_tready;
   logic [6*FIELD_W-1:0]   req_tdata   = '0;  // accel_x/y/z, gyro_x/y/z, 16 bits each
   logic                   rsp_tvalid;
   logic                   rsp_tready  = 1'b0;
   logic [2*FIELD_W-1:0]   rsp_tdata;         // motion_level, rotation_level
   logic                   csr_wen     = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index   = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata   = '0;

   feature_scoreboard_type board;
   int  cycle_count = 0;
   bit  send_steady = 1'b0;
   bit  take_steady = 1'b0;

   imu_motion_feature_extract_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // clock
   initial begin
      forever #(CLOCK_HALF) clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("imu_motion_feature_extract_unit_tb: errors");
         $finish;
      end
   end

   function automatic int draw_wait(bit steady);
      return steady ? 0 : int'($urandom_range(0, MAX_WAIT));
   endfunction

   // result side: random stalls, check every accepted item
   initial begin : result_taker
      int stall;
      while (reset) @(posedge clock);
      forever begin
         stall = draw_wait(take_steady);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         board.check_result(rsp_tdata);
      end
   end

   // one sample item, valid held until accepted
   task automatic send_sample(imu_sample_type s);
      int gap;
      gap = draw_wait(send_steady);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= s;
      do @(posedge clock); while (!req_tready);
      board.note_sample(s);
   endtask

   // stop sending and let the pipeline empty
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // register write; the caller lowers csr_wen after the last one
   task automatic write_csr(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
      csr_wen   <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      board.write_register(index, value);
   endtask

   function automatic imu_sample_type make_sample(int ax, int ay, int az,
                                                  int gx, int gy, int gz);
      imu_sample_type s;
      s.accel_x = ax[FIELD_W-1:0];
      s.accel_y = ay[FIELD_W-1:0];
      s.accel_z = az[FIELD_W-1:0];
      s.gyro_x  = gx[FIELD_W-1:0];
      s.gyro_y  = gy[FIELD_W-1:0];
      s.gyro_z  = gz[FIELD_W-1:0];
      return s;
   endfunction

   function automatic int noise(int span);
      return int'($urandom_range(0, 2 * span)) - span;
   endfunction

   // counts of every size: full range, short signed values, edge values
   function automatic int random_count();
      int w;
      int v;
      case ($urandom_range(0, 3))
         0: return int'($urandom_range(0, 65535)) - 32768;
         3: begin
            case ($urandom_range(0, 4))
               0: return -32768;
               1: return 32767;
               2: return 0;
               3: return -1;
               default: return 1;
            endcase
         end
         default: begin
            w = $urandom_range(1, 15);
            v = int'($urandom_range(0, (1 << w) - 1));
            return $urandom_range(0, 1) ? -v : v;
         end
      endcase
   endfunction

   // four in ten draws are a device at rest near one g with small turns, else free-form
   function automatic imu_sample_type random_sample();
      int axis;
      int lift;
      int acc[3];
      if ($urandom_range(0, 9) < 4) begin
         axis = $urandom_range(0, 2);
         lift = int'(board.gravity_level) + noise(3000);
         if (lift > 32767) lift = 32767;
         if (lift < 0) lift = 0;
         for (int i = 0; i < 3; i++)
            acc[i] = noise(1500);
         acc[axis] = $urandom_range(0, 1) ? -lift : lift;
         return make_sample(acc[0], acc[1], acc[2],
                            noise(4000), noise(4000), noise(4000));
      end
      return make_sample(random_count(), random_count(), random_count(),
                         random_count(), random_count(), random_count());
   endfunction

   // register settings per phase, extremes first
   task automatic apply_settings(int phase);
      case (phase)
         1: begin
            write_csr(CSR_GRAVITY_LEVEL, '0);
            write_csr(CSR_MOTION_GAIN, GAIN_MAX);
            write_csr(CSR_ROTATION_GAIN, GAIN_MAX);
         end
         2: begin
            write_csr(CSR_GRAVITY_LEVEL, 18'h0FFFF);
            write_csr(CSR_MOTION_GAIN, '0);
            write_csr(CSR_ROTATION_GAIN, '0);
         end
         3: begin
            // value wider than gravity_level, then a write to no register
            write_csr(CSR_GRAVITY_LEVEL, 18'h2ABCD);
            write_csr(CSR_MOTION_GAIN, 18'd1);
            write_csr(CSR_ROTATION_GAIN, 18'd1);
            write_csr(CSR_UNUSED_INDEX, GAIN_MAX);
         end
         default: begin
            write_csr(CSR_UNUSED_INDEX, CSR_DATA_W'($urandom_range(0, GAIN_MAX)));
            write_csr(CSR_GRAVITY_LEVEL, CSR_DATA_W'($urandom_range(0, 3) == 0 ?
                      $urandom_range(0, GAIN_MAX) : $urandom_range(12000, 20000)));
            write_csr(CSR_MOTION_GAIN, CSR_DATA_W'($urandom_range(0, GAIN_MAX)));
            write_csr(CSR_ROTATION_GAIN, CSR_DATA_W'($urandom_range(0, GAIN_MAX)));
         end
      endcase
      csr_wen <= 1'b0;
   endtask

   // stimulus
   initial begin : stimulus
      board = new();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed items at reset settings
      send_sample(make_sample(0, 0, 0, 0, 0, 0));
      send_sample(make_sample(-32768, -32768, -32768, -32768, -32768, -32768));
      send_sample(make_sample(32767, 32767, 32767, 32767, 32767, 32767));
      send_sample(make_sample(-32768, 32767, -32768, 32767, -32768, 32767));
      send_sample(make_sample(0, 0, 16384, 0, 0, 0));
      send_sample(make_sample(0, -16384, 0, 0, 0, 1));
      send_sample(make_sample(16383, 0, 0, -1, -1, -1));
      send_sample(make_sample(0, 0, 16385, 1, 1, 1));
      send_sample(make_sample(1, 1, 1, 0, 0, -32768));
      send_sample(make_sample(0, 0, -32768, 32767, 0, 0));
      send_sample(make_sample(9459, 9459, 9459, 0, 0, 0));
      send_sample(make_sample(16384, 16384, 16384, 20000, -20000, 20000));
      send_sample(make_sample(-1, -1, -1, 100, -100, 50));
      send_sample(make_sample(3, 4, 0, 3, 4, 12));
      send_sample(make_sample(0, 0, 16384 + 40960 / 4, 47160, 0, 0));
      send_sample(make_sample(-21845, 0, 0, 0, -27228, -27228));
      send_sample(make_sample(0, 0, 0, 32767, 32767, -32768));
      send_sample(make_sample(0, 16384, 0, 0, 0, 0));
      wait_idle();

      // random items over a series of settings
      for (int phase = 1; phase <= SETTING_PHASES; phase++) begin
         send_steady = (phase % 3 == 1);
         take_steady = (phase % 3 == 2);
         apply_settings(phase);
         for (int n = 0; n < PHASE_ITEMS; n++)
            send_sample(random_sample());
         wait_idle();
      end

      if (board.errors == 0)
         $display("imu_motion_feature_extract_unit_tb: clean");
      else
         $display("imu_motion_feature_extract_unit_tb: errors");
      $finish;
   end

endmodule

// File: imu_motion_feature_extract_unit.f
rtl/imfe_pkg.sv
rtl/imfe_mag_lane.sv
rtl/imfe_scale_merge.sv
rtl/imu_motion_feature_extract_unit.sv
verif/imu_motion_feature_extract_unit_tb.sv
